### rtl/ppdw_pkg.sv
package ppdw_pkg;

  // buffer geometry, counted in 32-bit words
  localparam int unsigned STAGE_PAIRS       = 2048;
  localparam int unsigned BURSTS_PER_BUFFER = 1024;
  localparam longint unsigned STAGE_WORDS   = 64'(STAGE_PAIRS) * 64'd2;
  localparam longint unsigned BUFFER_WORDS  = STAGE_WORDS * 64'(BURSTS_PER_BUFFER);

  // fill counters are wide enough to hold a full stage and a full buffer
  localparam int unsigned STG_W  = $clog2(STAGE_WORDS + 64'd1);
  localparam int unsigned BF_W   = $clog2(BUFFER_WORDS + 64'd1);
  localparam int unsigned SIZE_W = 23;

  localparam logic [STG_W-1:0]  STAGE_WORDS_F  = STG_W'(STAGE_WORDS);
  localparam logic [BF_W-1:0]   BUFFER_WORDS_F = BF_W'(BUFFER_WORDS);
  localparam logic [31:0]       BUFFER_WORDS_A = 32'(BUFFER_WORDS);
  localparam logic [STG_W-1:0]  PAIR_STEP      = STG_W'(2);

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000000;

  // configuration register indexes
  localparam logic [1:0] CFG_DDR_OFFSET    = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_LIMIT = 2'd1;

  localparam int unsigned IN_W  = 72;
  localparam int unsigned OUT_W = 408;

  typedef struct packed {
    logic [31:0] ddr_offset;
    logic [31:0] timeout_limit;
  } ppdw_cfg_t;

  typedef struct packed {
    logic        run;
    logic        data_valid;
    logic [63:0] data_word;
    logic [1:0]  host_ack;
  } ppdw_item_t;

  typedef struct packed {
    logic              data_taken;
    logic [31:0]       write_address;
    logic [63:0]       write_data;
    logic [1:0]        held_status;
    logic              interrupt;
    logic              fifo_clr_n;
    logic [SIZE_W-1:0] size_0;
    logic [SIZE_W-1:0] size_1;
    logic [63:0]       seq_0;
    logic [63:0]       seq_1;
    logic [63:0]       out_count;
    logic [63:0]       lost_count;
  } ppdw_result_t;

endpackage

### rtl/ping_pong_dma_buffer_writer.sv
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       run, data_valid, data_word, host_ack
// m_axis    out        m_axis_tvalid/tready       one result item per input item
// cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i (always ready)
//
// one item per clock: the state update is a single pass of logic, results are
// registered in a two-entry output buffer so input keeps flowing while the
// second entry is free; the input stalls only when both entries are full
// a result item is registered in the output buffer and offered once any result ahead of it is taken
// reset (rst_ni low) clears all state and loads timeout_limit with 10000000
// run low in an item clears the buffer state and returns an all-zero result
module ping_pong_dma_buffer_writer import ppdw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // run[0], data_valid[1], data_word[65:2], host_ack[67:66], unused pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // data_taken[0], write_address[32:1], write_data[96:33], held_status[98:97],
  // interrupt[99], fifo_clr_n[100], size_0[123:101], size_1[146:124],
  // seq_0[210:147], seq_1[274:211], out_count[338:275], lost_count[402:339], pad
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  ppdw_cfg_t    cfg_q;
  ppdw_item_t   item;
  ppdw_result_t core_res;
  ppdw_result_t buf_res;
  logic         fire;

  // configuration registers, writes to unused indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ddr_offset    <= 32'd0;
      cfg_q.timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DDR_OFFSET:    cfg_q.ddr_offset    <= cfg_data_i;
        CFG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // unpack the input item
  assign item.run        = s_axis_tdata[0];
  assign item.data_valid = s_axis_tdata[1];
  assign item.data_word  = s_axis_tdata[65:2];
  assign item.host_ack   = s_axis_tdata[67:66];

  assign fire = s_axis_tvalid && s_axis_tready;

  ppdw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (core_res)
  );

  ppdw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (core_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (buf_res)
  );

  // pack the result item, listed from the highest field down to data_taken at bit 0
  assign m_axis_tdata = {5'd0,
                         buf_res.lost_count,
                         buf_res.out_count,
                         buf_res.seq_1,
                         buf_res.seq_0,
                         buf_res.size_1,
                         buf_res.size_0,
                         buf_res.fifo_clr_n,
                         buf_res.interrupt,
                         buf_res.held_status,
                         buf_res.write_data,
                         buf_res.write_address,
                         buf_res.data_taken};

endmodule

### rtl/ppdw_core.sv
module ppdw_core import ppdw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  ppdw_item_t   item_i,
  input  ppdw_cfg_t    cfg_i,
  output ppdw_result_t result_o
);

  logic [1:0]        held_q, held_d;
  logic              cur_q, cur_d;
  logic [STG_W-1:0]  stg_q, stg_d;
  logic [BF_W-1:0]   bf_q, bf_d;
  logic [31:0]       tick_q, tick_d;
  logic              pend_q, pend_d;
  logic [1:0]        ack_q, ack_d;
  logic [63:0]       swcnt_q, swcnt_d;
  logic [63:0]       sstore_q [2];
  logic [63:0]       sstore_d [2];
  logic [63:0]       pseq_q [2];
  logic [63:0]       pseq_d [2];
  logic [SIZE_W-1:0] psize_q [2];
  logic [SIZE_W-1:0] psize_d [2];
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       stall_q, stall_d;
  logic              irq_q, irq_d;

  logic              held_cur;
  logic              taken;
  logic [STG_W-1:0]  stg_add;
  logic              stage_full;
  logic              close;
  logic [BF_W-1:0]   bf_sum;
  logic              do_swap;
  logic [31:0]       tick_base;
  logic [31:0]       addr;
  logic [1:0]        status;

  always_comb begin
    held_d   = held_q;
    cur_d    = cur_q;
    stg_d    = stg_q;
    bf_d     = bf_q;
    tick_d   = tick_q;
    pend_d   = pend_q;
    ack_d    = ack_q;
    swcnt_d  = swcnt_q;
    sstore_d = sstore_q;
    pseq_d   = pseq_q;
    psize_d  = psize_q;
    acc_d    = acc_q;
    stall_d  = stall_q;
    irq_d    = irq_q;

    held_cur   = held_q[cur_q];
    taken      = item_i.data_valid && !held_cur;
    stg_add    = stg_q + PAIR_STEP;
    stage_full = taken && (stg_add >= STAGE_WORDS_F);
    addr       = (cfg_i.ddr_offset >> 2) + (cur_q ? BUFFER_WORDS_A : 32'd0)
               + 32'(bf_q) + 32'(stg_q);
    if (taken) begin
      stg_d = stg_add;
      acc_d = acc_q + 64'd1;
    end
    if (held_cur) begin
      stall_d = stall_q + 64'd1;
    end

    close   = (stage_full || pend_q) && !held_cur;
    bf_sum  = bf_q + BF_W'(stg_d);
    do_swap = close && ((bf_sum >= BUFFER_WORDS_F) || pend_q);
    if (close) begin
      stg_d = '0;
      bf_d  = bf_sum;
    end
    if (do_swap) begin
      held_d[cur_q]     = 1'b1;
      psize_d[cur_q]    = SIZE_W'(bf_sum);
      pend_d            = 1'b0;
      bf_d              = '0;
      cur_d             = !cur_q;
      swcnt_d           = swcnt_q + 64'd1;
      sstore_d[!cur_q]  = swcnt_d;
      pseq_d            = sstore_d;
      irq_d             = 1'b1;
    end

    status = held_d;

    // rising acknowledge frees the buffer
    held_d = held_d & ~(item_i.host_ack & ~ack_q);
    ack_d  = item_i.host_ack;

    tick_base = do_swap ? 32'd0 : tick_q;
    if (tick_base == cfg_i.timeout_limit) begin
      pend_d = 1'b1;
      tick_d = 32'd0;
    end else begin
      tick_d = tick_base + 32'd1;
    end

    result_o.data_taken    = taken;
    result_o.write_address = taken ? addr : 32'd0;
    result_o.write_data    = taken ? item_i.data_word : 64'd0;
    result_o.held_status   = status;
    result_o.interrupt     = irq_d;
    result_o.fifo_clr_n    = 1'b1;
    result_o.size_0        = psize_d[0];
    result_o.size_1        = psize_d[1];
    result_o.seq_0         = pseq_d[0];
    result_o.seq_1         = pseq_d[1];
    result_o.out_count     = acc_d;
    result_o.lost_count    = stall_d;

    if (!item_i.run) begin
      held_d      = '0;
      cur_d       = 1'b0;
      stg_d       = '0;
      bf_d        = '0;
      tick_d      = '0;
      pend_d      = 1'b0;
      ack_d       = '0;
      swcnt_d     = '0;
      sstore_d[0] = '0;
      sstore_d[1] = '0;
      pseq_d[0]   = '0;
      pseq_d[1]   = '0;
      psize_d[0]  = '0;
      psize_d[1]  = '0;
      acc_d       = '0;
      stall_d     = '0;
      irq_d       = 1'b0;
      result_o    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      cur_q       <= 1'b0;
      stg_q       <= '0;
      bf_q        <= '0;
      tick_q      <= '0;
      pend_q      <= 1'b0;
      ack_q       <= '0;
      swcnt_q     <= '0;
      sstore_q[0] <= '0;
      sstore_q[1] <= '0;
      pseq_q[0]   <= '0;
      pseq_q[1]   <= '0;
      psize_q[0]  <= '0;
      psize_q[1]  <= '0;
      acc_q       <= '0;
      stall_q     <= '0;
      irq_q       <= 1'b0;
    end else if (fire_i) begin
      held_q   <= held_d;
      cur_q    <= cur_d;
      stg_q    <= stg_d;
      bf_q     <= bf_d;
      tick_q   <= tick_d;
      pend_q   <= pend_d;
      ack_q    <= ack_d;
      swcnt_q  <= swcnt_d;
      sstore_q <= sstore_d;
      pseq_q   <= pseq_d;
      psize_q  <= psize_d;
      acc_q    <= acc_d;
      stall_q  <= stall_d;
      irq_q    <= irq_d;
    end
  end

endmodule

### rtl/ppdw_out_buf.sv
module ppdw_out_buf import ppdw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ppdw_result_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output ppdw_result_t out_data_o
);

  ppdw_result_t out_q;
  ppdw_result_t skid_q;
  logic         out_valid_q;
  logic         skid_valid_q;
  logic         push;
  logic         pop;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= in_data_i;
        end
      end else if (push) begin
        out_q <= in_data_i;
      end
    end else if (push) begin
      skid_q <= in_data_i;
    end
  end

endmodule
